@@ rtl/c2d_pkg.sv @@
package c2d_pkg;

   localparam int CMD_W    = 2;
   localparam int ROW_W    = 8;
   localparam int COL_W    = 8;
   localparam int ICH_W    = 2;
   localparam int OCH_W    = 4;
   localparam int TAP_W    = 2;
   localparam int DATA_W   = 16;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int RESULT_W = 40;

   localparam int K_SIZE = 3;
   localparam int K_TAPS = K_SIZE * K_SIZE;
   localparam int PAD    = 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIM_W      = 9;
   localparam int NIC_W      = 3;
   localparam int NOC_W      = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_WR_WEIGHT = 2'd0,
      CMD_WR_SAMPLE = 2'd1,
      CMD_COMPUTE   = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_IN_CH  = 2'd2,
      CSR_OUT_CH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic step;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic range_bad;
      logic last_tap;
      logic pipe_busy;
   } dp_sts_type;

endpackage

@@ rtl/c2d_if.sv @@
interface c2d_req_if import c2d_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [ROW_W-1:0]         pixel_row;
   logic [COL_W-1:0]         pixel_col;
   logic [ICH_W-1:0]         in_channel;
   logic [OCH_W-1:0]         out_channel;
   logic [TAP_W-1:0]         tap_row;
   logic [TAP_W-1:0]         tap_col;
   logic signed [DATA_W-1:0] data_value;

   modport source (output valid, command, pixel_row, pixel_col, in_channel, out_channel,
                   tap_row, tap_col, data_value, input ready);
   modport sink (input valid, command, pixel_row, pixel_col, in_channel, out_channel,
                 tap_row, tap_col, data_value, output ready);
endinterface

interface c2d_rsp_if import c2d_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] conv_result;
   logic                       status;

   modport source (output valid, conv_result, status, input ready);
   modport sink (input valid, conv_result, status, output ready);
endinterface

interface c2d_csr_if import c2d_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] reg_data;

   modport source (output valid, reg_index, reg_data, input ready);
   modport sink (input valid, reg_index, reg_data, output ready);
endinterface

@@ rtl/conv2d_3x3_same_pad_core.sv @@
// channel  dir  handshake     payload
// req_ch   in   valid/ready   command, pixel_row, pixel_col, in_channel, out_channel,
//                             tap_row, tap_col, data_value
// rsp_ch   out  valid/ready   conv_result, status (compute items only)
// csr_ch   in   valid/ready   reg_index, reg_data (ready always high)
//
// Write items are taken while idle. A compute item walks the 3x3 taps of each input
// channel in use, one multiply-accumulate per in-image tap over the sample and weight
// memory read ports. An out-of-range compute issues no taps. Reset is synchronous,
// active high, and clears control only; both memories hold garbage until written.
// A stalled result waits in the output register while write items are still taken.
module conv2d_3x3_same_pad_core import c2d_pkg::*; #(
   parameter int MAX_WIDTH        = 256,
   parameter int MAX_HEIGHT       = 256,
   parameter int MAX_IN_CHANNELS  = 4,
   parameter int MAX_OUT_CHANNELS = 16
) (
   input logic       clock,
   input logic       reset,
   c2d_req_if.sink   req_ch,
   c2d_rsp_if.source rsp_ch,
   c2d_csr_if.sink   csr_ch
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;
   logic       req_fire;
   logic       csr_fire;
   logic       rsp_valid;

   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign rsp_ch.valid = rsp_valid;

   c2d_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ready),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_valid),
      .cmd         (cmd),
      .sts         (sts)
   );

   c2d_dp #(
      .MAX_WIDTH        (MAX_WIDTH),
      .MAX_HEIGHT       (MAX_HEIGHT),
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_fire        (req_fire),
      .req_command     (req_ch.command),
      .req_pixel_row   (req_ch.pixel_row),
      .req_pixel_col   (req_ch.pixel_col),
      .req_in_channel  (req_ch.in_channel),
      .req_out_channel (req_ch.out_channel),
      .req_tap_row     (req_ch.tap_row),
      .req_tap_col     (req_ch.tap_col),
      .req_data_value  (req_ch.data_value),
      .csr_fire        (csr_fire),
      .csr_index       (csr_ch.reg_index),
      .csr_data        (csr_ch.reg_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_conv_result (rsp_ch.conv_result),
      .rsp_status      (rsp_ch.status)
   );

`ifndef SYNTHESIS
   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !sts.pipe_busy)
      else $error("result loaded while taps in flight");

   a_no_step_out_of_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !sts.range_bad)
      else $error("tap issued for out-of-range compute");

   a_compute_blocks_input: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_ch.ready)
      else $error("input taken during compute");

   a_load_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_ch.valid)
      else $error("loaded result not presented");
`endif

endmodule

@@ rtl/c2d_ctrl.sv @@
module c2d_ctrl import c2d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output dp_cmd_type       cmd,
   input  dp_sts_type       sts
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_command == CMD_COMPUTE)) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.range_bad) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.step = 1'b1;
               if (sts.last_tap) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/c2d_dp.sv @@
module c2d_dp import c2d_pkg::*; #(
   parameter int MAX_WIDTH        = 256,
   parameter int MAX_HEIGHT       = 256,
   parameter int MAX_IN_CHANNELS  = 4,
   parameter int MAX_OUT_CHANNELS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_fire,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [ROW_W-1:0]           req_pixel_row,
   input  logic [COL_W-1:0]           req_pixel_col,
   input  logic [ICH_W-1:0]           req_in_channel,
   input  logic [OCH_W-1:0]           req_out_channel,
   input  logic [TAP_W-1:0]           req_tap_row,
   input  logic [TAP_W-1:0]           req_tap_col,
   input  logic signed [DATA_W-1:0]   req_data_value,
   input  logic                       csr_fire,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  dp_cmd_type                 cmd,
   output dp_sts_type                 sts,
   output logic signed [RESULT_W-1:0] rsp_conv_result,
   output logic                       rsp_status
);

   localparam int SAMPLE_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_IN_CHANNELS;
   localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * K_TAPS;
   localparam int SA_W = $clog2(SAMPLE_DEPTH);
   localparam int WA_W = $clog2(WEIGHT_DEPTH);
   localparam int CH_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;

   logic [DIM_W-1:0] width_ff, height_ff, w_use, h_use;
   logic [NIC_W-1:0] in_ch_ff, nic_use;
   logic [NOC_W-1:0] out_ch_ff, noc_use;

   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;
   logic [OCH_W-1:0] oc_ff;
   logic             range_bad_ff, range_bad_in;

   logic [CH_W-1:0]  chan_ff;
   logic [TAP_W-1:0] trow_ff, tcol_ff;
   logic             last_tap;

   logic [DIM_W-1:0] rr_full, cc_full;
   logic             tap_inb;

   logic             s1_valid_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [CH_W-1:0]  s1_chan_ff;
   logic [TAP_W-1:0] s1_trow_ff, s1_tcol_ff;
   logic             s1_inb_ff;

   logic [SA_W-1:0]  s_rd_addr, s_wr_addr;
   logic [WA_W-1:0]  w_rd_addr, w_wr_addr;
   logic             sample_we, weight_we;

   logic [DATA_W-1:0] sample_mem [SAMPLE_DEPTH];
   logic [DATA_W-1:0] weight_mem [WEIGHT_DEPTH];

   logic                       s2_valid_ff;
   logic signed [DATA_W-1:0]   s_rd_ff, w_rd_ff;
   logic                       s3_valid_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [RESULT_W-1:0] acc_ff;
   logic signed [RESULT_W-1:0] out_result_ff;
   logic                       out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(256);
         height_ff <= DIM_W'(256);
         in_ch_ff  <= NIC_W'(3);
         out_ch_ff <= NOC_W'(16);
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[DIM_W-1:0];
            CSR_IN_CH:  in_ch_ff  <= csr_data[NIC_W-1:0];
            CSR_OUT_CH: out_ch_ff <= csr_data[NOC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) w_use = DIM_W'(1);
      else if (width_ff > MAX_WIDTH) w_use = DIM_W'(MAX_WIDTH);
      else w_use = width_ff;
      if (height_ff == '0) h_use = DIM_W'(1);
      else if (height_ff > MAX_HEIGHT) h_use = DIM_W'(MAX_HEIGHT);
      else h_use = height_ff;
      if (in_ch_ff == '0) nic_use = NIC_W'(1);
      else if (in_ch_ff > MAX_IN_CHANNELS) nic_use = NIC_W'(MAX_IN_CHANNELS);
      else nic_use = in_ch_ff;
      if (out_ch_ff == '0) noc_use = NOC_W'(1);
      else if (out_ch_ff > MAX_OUT_CHANNELS) noc_use = NOC_W'(MAX_OUT_CHANNELS);
      else noc_use = out_ch_ff;
   end

   assign range_bad_in = ({1'b0, req_pixel_row} >= h_use) || ({1'b0, req_pixel_col} >= w_use)
                      || ({1'b0, req_out_channel} >= noc_use);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff       <= req_pixel_row;
         col_ff       <= req_pixel_col;
         oc_ff        <= req_out_channel;
         range_bad_ff <= range_bad_in;
      end
   end

   assign last_tap = (tcol_ff == TAP_W'(K_SIZE - 1)) && (trow_ff == TAP_W'(K_SIZE - 1))
                  && (chan_ff == (nic_use - NIC_W'(1)));

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         chan_ff <= '0;
         trow_ff <= '0;
         tcol_ff <= '0;
      end else if (cmd.step) begin
         if (tcol_ff == TAP_W'(K_SIZE - 1)) begin
            tcol_ff <= '0;
            if (trow_ff == TAP_W'(K_SIZE - 1)) begin
               trow_ff <= '0;
               chan_ff <= chan_ff + CH_W'(1);
            end else begin
               trow_ff <= trow_ff + TAP_W'(1);
            end
         end else begin
            tcol_ff <= tcol_ff + TAP_W'(1);
         end
      end
   end

   assign rr_full = {1'b0, row_ff} + DIM_W'(trow_ff);
   assign cc_full = {1'b0, col_ff} + DIM_W'(tcol_ff);
   assign tap_inb = (rr_full >= DIM_W'(PAD)) && (cc_full >= DIM_W'(PAD))
                 && ((rr_full - DIM_W'(PAD)) < h_use) && ((cc_full - DIM_W'(PAD)) < w_use);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.step;
      end
      s1_row_ff  <= ROW_W'(rr_full - DIM_W'(PAD));
      s1_col_ff  <= COL_W'(cc_full - DIM_W'(PAD));
      s1_chan_ff <= chan_ff;
      s1_trow_ff <= trow_ff;
      s1_tcol_ff <= tcol_ff;
      s1_inb_ff  <= tap_inb;
   end

   assign s_rd_addr = SA_W'((int'(s1_row_ff) * MAX_WIDTH + int'(s1_col_ff)) * MAX_IN_CHANNELS
                            + int'(s1_chan_ff));
   assign w_rd_addr = WA_W'(((int'(oc_ff) * MAX_IN_CHANNELS + int'(s1_chan_ff)) * K_SIZE
                             + int'(s1_trow_ff)) * K_SIZE + int'(s1_tcol_ff));
   assign s_wr_addr = SA_W'((int'(req_pixel_row) * MAX_WIDTH + int'(req_pixel_col))
                            * MAX_IN_CHANNELS + int'(req_in_channel));
   assign w_wr_addr = WA_W'(((int'(req_out_channel) * MAX_IN_CHANNELS + int'(req_in_channel))
                             * K_SIZE + int'(req_tap_row)) * K_SIZE + int'(req_tap_col));

   assign sample_we = req_fire && (req_command == CMD_WR_SAMPLE)
                   && (req_pixel_row < MAX_HEIGHT) && (req_pixel_col < MAX_WIDTH)
                   && (req_in_channel < MAX_IN_CHANNELS);
   assign weight_we = req_fire && (req_command == CMD_WR_WEIGHT)
                   && (req_tap_row < K_SIZE) && (req_tap_col < K_SIZE)
                   && (req_in_channel < MAX_IN_CHANNELS) && (req_out_channel < MAX_OUT_CHANNELS);

   always_ff @(posedge clock) begin
      if (sample_we) begin
         sample_mem[s_wr_addr] <= req_data_value;
      end
      s_rd_ff <= sample_mem[s_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[w_wr_addr] <= req_data_value;
      end
      w_rd_ff <= weight_mem[w_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_inb_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      prod_ff <= s_rd_ff * w_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (s3_valid_ff) begin
         acc_ff <= acc_ff + RESULT_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_result_ff <= range_bad_ff ? '0 : acc_ff;
         out_status_ff <= range_bad_ff;
      end
   end

   assign sts.range_bad   = range_bad_ff;
   assign sts.last_tap    = last_tap;
   assign sts.pipe_busy   = s1_valid_ff || s2_valid_ff || s3_valid_ff;
   assign rsp_conv_result = out_result_ff;
   assign rsp_status      = out_status_ff;

endmodule

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import c2d_pkg::*;

   localparam int MAX_W  = 256;
   localparam int MAX_H  = 256;
   localparam int MAX_IC = 4;
   localparam int MAX_OC = 16;

   localparam int ITEM_GOAL    = 1700;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [ICH_W-1:0]  ich;
      logic [OCH_W-1:0]  och;
      logic [TAP_W-1:0]  trow;
      logic [TAP_W-1:0]  tcol;
      logic [DATA_W-1:0] value;
   } conv_cmd_type;

   typedef struct packed {
      logic [RESULT_W-1:0] sum;
      logic                bad;
   } conv_out_type;

   typedef struct packed {
      conv_cmd_type it;
      logic         pin;
      conv_out_type fix;
   } script_row_type;

   logic clock;
   logic reset;

   c2d_req_if req_ch();
   c2d_rsp_if rsp_ch();
   c2d_csr_if csr_ch();

   conv2d_3x3_same_pad_core #(
      .MAX_WIDTH        (MAX_W),
      .MAX_HEIGHT       (MAX_H),
      .MAX_IN_CHANNELS  (MAX_IC),
      .MAX_OUT_CHANNELS (MAX_OC)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bit [DATA_W-1:0] pix_mem [int];
   bit [DATA_W-1:0] wgt_mem [int];
   int img_w   = 256;
   int img_h   = 256;
   int used_ic = 3;
   int used_oc = 16;

   conv_out_type   sums_due [$];
   script_row_type script [$];
   int faults     = 0;
   int items_sent = 0;
   bit calm       = 0;
   bit squeeze    = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int fit(int v, int hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic int pix_at(int r, int c, int ch);
      return (r * MAX_W + c) * MAX_IC + ch;
   endfunction

   function automatic int wgt_at(int oc, int ic, int tr, int tc);
      return ((oc * MAX_IC + ic) * K_SIZE + tr) * K_SIZE + tc;
   endfunction

   function automatic int nudge(int base, int lim);
      int v;
      v = base + int'($urandom_range(0, 4)) - 2;
      return (v < 0) ? 0 : ((v >= lim) ? lim - 1 : v);
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] v;
      v = DATA_W'($urandom);
      case ($urandom_range(0, 11))
         0: v = 16'h8000;
         1: v = 16'h7fff;
         2: v = 16'hffff;
         3: v = 16'h0000;
         default: ;
      endcase
      return v;
   endfunction

   function automatic conv_cmd_type scramble();
      logic [63:0]  r;
      conv_cmd_type it;
      r = {$urandom, $urandom};
      it = r[$bits(conv_cmd_type)-1:0];
      return it;
   endfunction

   function automatic void script_add(input logic [CMD_W-1:0] cmd, input int row, input int col,
                                      input int ich, input int och, input int tr, input int tc,
                                      input logic [DATA_W-1:0] v, input bit pin = 1'b0,
                                      input logic [RESULT_W-1:0] s = '0, input logic bad = 1'b0);
      script_row_type e;
      e.it.cmd   = cmd;
      e.it.row   = ROW_W'(row);
      e.it.col   = COL_W'(col);
      e.it.ich   = ICH_W'(ich);
      e.it.och   = OCH_W'(och);
      e.it.trow  = TAP_W'(tr);
      e.it.tcol  = TAP_W'(tc);
      e.it.value = v;
      e.pin      = pin;
      e.fix.sum  = s;
      e.fix.bad  = bad;
      script.push_back(e);
   endfunction

   function automatic void log_fault(string what, conv_out_type want, conv_out_type got);
      faults++;
      if (faults <= 10)
         $display("%0t: %s: expected sum %h status %0b, got sum %h status %0b",
                  $time, what, want.sum, want.bad, got.sum, got.bad);
   endfunction

   // update the stores and work out the sum of one window
   function automatic void conv_step(input conv_cmd_type it, output bit has_out,
                                     output conv_out_type o);
      longint acc;
      int     rr;
      int     cc;
      has_out = 1'b0;
      o = '0;
      case (it.cmd)
         CMD_WR_WEIGHT: begin
            if (it.trow < K_SIZE && it.tcol < K_SIZE)
               wgt_mem[wgt_at(it.och, it.ich, it.trow, it.tcol)] = it.value;
         end
         CMD_WR_SAMPLE: begin
            pix_mem[pix_at(it.row, it.col, it.ich)] = it.value;
         end
         CMD_COMPUTE: begin
            has_out = 1'b1;
            if (it.row >= img_h || it.col >= img_w || it.och >= used_oc) begin
               o.bad = 1'b1;
            end else begin
               acc = 0;
               for (int ch = 0; ch < used_ic; ch++)
                  for (int r = 0; r < K_SIZE; r++)
                     for (int s = 0; s < K_SIZE; s++) begin
                        rr = int'(it.row) + r - PAD;
                        cc = int'(it.col) + s - PAD;
                        if (rr < 0 || cc < 0 || rr >= img_h || cc >= img_w) continue;
                        acc += longint'($signed(pix_mem[pix_at(rr, cc, ch)])) *
                               longint'($signed(wgt_mem[wgt_at(it.och, ch, r, s)]));
                     end
               o.sum = acc[RESULT_W-1:0];
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_cmd(input conv_cmd_type it, input bit pin, input conv_out_type fix);
      bit           has_out;
      conv_out_type o;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= it.cmd;
      req_ch.pixel_row   <= it.row;
      req_ch.pixel_col   <= it.col;
      req_ch.in_channel  <= it.ich;
      req_ch.out_channel <= it.och;
      req_ch.tap_row     <= it.trow;
      req_ch.tap_col     <= it.tcol;
      req_ch.data_value  <= it.value;
      do @(posedge clock); while (!req_ch.ready);
      conv_step(it, has_out, o);
      if (has_out)
         sums_due.push_back(pin ? fix : o);
      if (it.cmd != CMD_UNUSED &&
          !(it.cmd == CMD_WR_WEIGHT && (it.trow >= K_SIZE || it.tcol >= K_SIZE)))
         items_sent++;
   endtask

   task automatic send_sample(input int r, input int c, input int ch);
      conv_cmd_type it;
      it = scramble();
      it.cmd   = CMD_WR_SAMPLE;
      it.row   = ROW_W'(r);
      it.col   = COL_W'(c);
      it.ich   = ICH_W'(ch);
      it.value = pick_value();
      send_cmd(it, 1'b0, '0);
   endtask

   task automatic send_weight(input int oc, input int ic, input int tr, input int tc);
      conv_cmd_type it;
      it = scramble();
      it.cmd   = CMD_WR_WEIGHT;
      it.och   = OCH_W'(oc);
      it.ich   = ICH_W'(ic);
      it.trow  = TAP_W'(tr);
      it.tcol  = TAP_W'(tc);
      it.value = pick_value();
      send_cmd(it, 1'b0, '0);
   endtask

   // fill every sample and weight the window will read that was never written
   task automatic prep_window(input int row, input int col, input int oc);
      int rr;
      int cc;
      if (row >= img_h || col >= img_w || oc >= used_oc) return;
      for (int ch = 0; ch < used_ic; ch++)
         for (int r = 0; r < K_SIZE; r++)
            for (int s = 0; s < K_SIZE; s++) begin
               rr = row + r - PAD;
               cc = col + s - PAD;
               if (rr < 0 || cc < 0 || rr >= img_h || cc >= img_w) continue;
               if (!pix_mem.exists(pix_at(rr, cc, ch))) send_sample(rr, cc, ch);
               if (!wgt_mem.exists(wgt_at(oc, ch, r, s))) send_weight(oc, ch, r, s);
            end
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.reg_data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_WIDTH:  img_w   = fit(data[DIM_W-1:0], MAX_W);
         CSR_HEIGHT: img_h   = fit(data[DIM_W-1:0], MAX_H);
         CSR_IN_CH:  used_ic = fit(data[NIC_W-1:0], MAX_IC);
         CSR_OUT_CH: used_oc = fit(data[NOC_W-1:0], MAX_OC);
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, wait for every pending sum, then let the datapath drain
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sums_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      conv_out_type got;
      conv_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.sum = rsp_ch.conv_result;
         got.bad = rsp_ch.status;
         if (sums_due.size() == 0) begin
            log_fault("result with none pending", '0, got);
         end else begin
            want = sums_due.pop_front();
            if (got !== want) log_fault("result mismatch", want, got);
         end
      end
   end

   initial begin : rsp_drain
      rsp_ch.ready <= 1'b1;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      conv_cmd_type      it;
      logic [DIM_W-1:0]  w_raw;
      logic [DIM_W-1:0]  h_raw;
      logic [NIC_W-1:0]  ic_raw;
      logic [NOC_W-1:0]  oc_raw;
      logic [15:0]       junk;
      int phase;
      int stop_at;
      int sel;
      int focus_r;
      int focus_c;
      int focus_oc;
      int r;
      int c;
      int oc;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= '0;
      req_ch.pixel_row   <= '0;
      req_ch.pixel_col   <= '0;
      req_ch.in_channel  <= '0;
      req_ch.out_channel <= '0;
      req_ch.tap_row     <= '0;
      req_ch.tap_col     <= '0;
      req_ch.data_value  <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.reg_index   <= '0;
      csr_ch.reg_data    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one pixel, one channel: only the center tap contributes
      csr_write(CSR_WIDTH, 16'd1);
      csr_write(CSR_HEIGHT, 16'd1);
      csr_write(CSR_IN_CH, 16'd1);
      csr_write(CSR_OUT_CH, 16'd1);

      script_add(CMD_WR_WEIGHT, 0, 0, 0, 0, 1, 1, 16'h8000);
      script_add(CMD_WR_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h8000);
      script_add(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 16'h0000, 1'b1, 40'h00_4000_0000, 1'b0);
      script_add(CMD_WR_WEIGHT, 0, 0, 0, 0, 1, 1, 16'h7fff);
      script_add(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 16'h0000, 1'b1, 40'hff_c000_8000, 1'b0);
      script_add(CMD_WR_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h7fff);
      script_add(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 16'h0000, 1'b1, 40'h00_3fff_0001, 1'b0);
      // taps off the kernel and the spare command must leave the stores alone
      script_add(CMD_WR_WEIGHT, 0, 0, 0, 0, 3, 1, 16'h0000);
      script_add(CMD_WR_WEIGHT, 0, 0, 0, 0, 1, 3, 16'h0000);
      script_add(CMD_UNUSED, 255, 255, 3, 15, 3, 3, 16'hffff);
      script_add(CMD_COMPUTE, 0, 0, 3, 0, 3, 3, 16'hffff, 1'b1, 40'h00_3fff_0001, 1'b0);
      script_add(CMD_COMPUTE, 1, 0, 0, 0, 0, 0, 16'h0000, 1'b1, 40'h0, 1'b1);
      script_add(CMD_COMPUTE, 0, 255, 0, 0, 0, 0, 16'h0000, 1'b1, 40'h0, 1'b1);
      script_add(CMD_COMPUTE, 255, 255, 3, 15, 3, 3, 16'hffff, 1'b1, 40'h0, 1'b1);
      script_add(CMD_COMPUTE, 0, 0, 0, 1, 0, 0, 16'h0000, 1'b1, 40'h0, 1'b1);
      script_add(CMD_WR_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h0000);
      script_add(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 16'h0000, 1'b1, 40'h0, 1'b0);
      script_add(CMD_WR_SAMPLE, 255, 255, 3, 15, 3, 3, 16'hffff);
      script_add(CMD_WR_WEIGHT, 255, 255, 3, 15, 2, 2, 16'hffff);
      script_add(CMD_WR_SAMPLE, 0, 0, 0, 0, 0, 0, 16'hff80);
      script_add(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 16'h0000);
      foreach (script[i]) send_cmd(script[i].it, script[i].pin, script[i].fix);

      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         settle();
         case (phase)
            0: begin
               w_raw = DIM_W'(256); h_raw = DIM_W'(256);
               ic_raw = NIC_W'(4);  oc_raw = NOC_W'(16);
            end
            1: begin
               w_raw = DIM_W'(0);   h_raw = DIM_W'(0);
               ic_raw = NIC_W'(0);  oc_raw = NOC_W'(0);
            end
            2: begin
               w_raw = DIM_W'(511); h_raw = DIM_W'(300);
               ic_raw = NIC_W'(7);  oc_raw = NOC_W'(31);
            end
            3: begin
               w_raw = DIM_W'(3);   h_raw = DIM_W'(3);
               ic_raw = NIC_W'(1);  oc_raw = NOC_W'(1);
            end
            default: begin
               w_raw  = DIM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                            : $urandom_range(1, 10));
               h_raw  = DIM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                            : $urandom_range(1, 10));
               ic_raw = NIC_W'($urandom_range(0, 7));
               oc_raw = NOC_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(1, 16));
            end
         endcase
         junk = 16'($urandom);
         csr_write(CSR_WIDTH, {junk[15:9], w_raw});
         csr_write(CSR_HEIGHT, {~junk[15:9], h_raw});
         csr_write(CSR_IN_CH, {junk[15:3], ic_raw});
         csr_write(CSR_OUT_CH, {~junk[15:5], oc_raw});

         focus_r  = $urandom_range(0, img_h - 1);
         focus_c  = $urandom_range(0, img_w - 1);
         focus_oc = $urandom_range(0, used_oc - 1);
         if (phase == 5) squeeze = 1'b1;

         stop_at = items_sent + 150;
         while (items_sent < stop_at) begin
            calm = (items_sent >= ITEM_GOAL * 17 / 20);
            sel = $urandom_range(0, 99);
            it = scramble();
            if (sel < 55) begin
               r  = nudge(focus_r, img_h);
               c  = nudge(focus_c, img_w);
               oc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, used_oc - 1) : focus_oc;
               case ($urandom_range(0, 15))
                  0: begin
                     r = ($urandom_range(0, 1) == 0) ? 0 : img_h - 1;
                     c = ($urandom_range(0, 1) == 0) ? 0 : img_w - 1;
                  end
                  1: if (img_h < MAX_H) r = $urandom_range(img_h, MAX_H - 1);
                  2: if (img_w < MAX_W) c = $urandom_range(img_w, MAX_W - 1);
                  3: if (used_oc < MAX_OC) oc = $urandom_range(used_oc, MAX_OC - 1);
                  default: ;
               endcase
               prep_window(r, c, oc);
               it.cmd = CMD_COMPUTE;
               it.row = ROW_W'(r);
               it.col = COL_W'(c);
               it.och = OCH_W'(oc);
               send_cmd(it, 1'b0, '0);
            end else if (sel < 75) begin
               send_sample(nudge(focus_r, MAX_H), nudge(focus_c, MAX_W), $urandom_range(0, 3));
            end else if (sel < 85) begin
               send_sample($urandom_range(0, MAX_H - 1), $urandom_range(0, MAX_W - 1),
                           $urandom_range(0, 3));
            end else if (sel < 97) begin
               send_weight($urandom_range(0, MAX_OC - 1), $urandom_range(0, MAX_IC - 1),
                           ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2),
                           ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2));
            end else begin
               it.cmd = CMD_UNUSED;
               send_cmd(it, 1'b0, '0);
            end
         end
         phase++;
      end

      settle();
      if (faults == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/c2d_pkg.sv
rtl/c2d_if.sv
rtl/c2d_ctrl.sv
rtl/c2d_dp.sv
rtl/conv2d_3x3_same_pad_core.sv
tb/testbench.sv
